FILE: src/cmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

	localparam int IDX_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int VAL_W     = 16;
	localparam int SQV_W     = 32;
	localparam int SUM_W     = 33;
	localparam int SQ_W      = 49;
	localparam int OUT_CNT_W = 17;
	localparam int STATUS_W  = 2;

	localparam logic [1:0] OP_ASSIGN = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BEYOND_USE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BEYOND_CAP = 2'd2;

	localparam logic [1:0] K_NONE   = 2'd0;
	localparam logic [1:0] K_UPDATE = 2'd1;
	localparam logic [1:0] K_REMOVE = 2'd2;
	localparam logic [1:0] K_CLEAR  = 2'd3;

	localparam logic [1:0] M_ADD  = 2'd0;
	localparam logic [1:0] M_SUB  = 2'd1;
	localparam logic [1:0] M_COPY = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic                two_step;
		logic [1:0]          mode;
		logic [IDX_W-1:0]    idx_a;
		logic [IDX_W-1:0]    idx_b;
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   size;
		logic [VAL_W-1:0]    value;
		logic [SQV_W-1:0]    square;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/cmt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cmt_front #(
	parameter int MAX_CLUSTERS = 64,
	parameter int VALUE_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [1:0]                   opcode,
	input  wire logic                         old_valid,
	input  wire logic [cmt_pkg::IDX_W-1:0]    prior_cluster,
	input  wire logic                         new_valid,
	input  wire logic [cmt_pkg::IDX_W-1:0]    new_cluster,
	input  wire logic [cmt_pkg::VAL_W-1:0]    point_value,
	input  wire logic [cmt_pkg::IDX_W-1:0]    source_cluster,
	input  wire logic [cmt_pkg::IDX_W-1:0]    target_cluster,
	input  wire logic [cmt_pkg::SIZE_W-1:0]   new_size,
	output cmt_pkg::cmd_t                     cmd
);

	localparam int CAP_W = $clog2(MAX_CLUSTERS + 1);
	localparam int CW    = (CAP_W > cmt_pkg::SIZE_W) ? CAP_W : cmt_pkg::SIZE_W;
	localparam logic [CW-1:0] CAP = CW'(MAX_CLUSTERS);
	localparam logic [cmt_pkg::VAL_W-1:0] VMASK = (VALUE_BITS >= cmt_pkg::VAL_W) ?
		{cmt_pkg::VAL_W{1'b1}} : cmt_pkg::VAL_W'((1 << VALUE_BITS) - 1);

	logic [cmt_pkg::SIZE_W-1:0] size_q;
	logic [cmt_pkg::SIZE_W-1:0] size_after;
	logic [CW-1:0]              size_w;
	logic [CW-1:0]              old_w;
	logic [CW-1:0]              new_w;
	logic [CW-1:0]              src_w;
	logic [CW-1:0]              tgt_w;
	logic [CW-1:0]              nsize_w;
	logic [cmt_pkg::VAL_W-1:0]  value;

	assign size_w  = CW'(size_q);
	assign old_w   = CW'(prior_cluster);
	assign new_w   = CW'(new_cluster);
	assign src_w   = CW'(source_cluster);
	assign tgt_w   = CW'(target_cluster);
	assign nsize_w = CW'(new_size);
	assign value   = point_value & VMASK;

	always_comb begin
		cmd          = '0;
		cmd.value    = value;
		cmd.square   = cmt_pkg::SQV_W'(value) * cmt_pkg::SQV_W'(value);
		cmd.kind     = cmt_pkg::K_NONE;
		cmd.status   = cmt_pkg::STAT_OK;
		cmd.mode     = cmt_pkg::M_COPY;
		size_after   = size_q;
		unique case (opcode)
			cmt_pkg::OP_ASSIGN: begin
				priority if (old_valid && old_w >= size_w) begin
					cmd.status = cmt_pkg::STAT_BEYOND_USE;
				end else if (new_valid && new_w >= CAP) begin
					cmd.status = cmt_pkg::STAT_BEYOND_CAP;
				end else if (old_valid || new_valid) begin
					cmd.kind = cmt_pkg::K_UPDATE;
					if (new_valid && new_w >= size_w) begin
						size_after = cmt_pkg::SIZE_W'(new_cluster) + cmt_pkg::SIZE_W'(1);
					end
					priority if (old_valid && new_valid && prior_cluster != new_cluster) begin
						cmd.two_step = 1'b1;
						cmd.idx_a    = prior_cluster;
						cmd.idx_b    = new_cluster;
						cmd.mode     = cmt_pkg::M_ADD;
					end else if (new_valid) begin
						cmd.idx_a = new_cluster;
						cmd.idx_b = new_cluster;
						cmd.mode  = old_valid ? cmt_pkg::M_COPY : cmt_pkg::M_ADD;
					end else begin
						cmd.idx_a = prior_cluster;
						cmd.idx_b = prior_cluster;
						cmd.mode  = cmt_pkg::M_SUB;
					end
				end else begin
					cmd.kind = cmt_pkg::K_NONE;
				end
			end
			cmt_pkg::OP_MOVE: begin
				if (src_w >= size_w || tgt_w >= size_w) begin
					cmd.status = cmt_pkg::STAT_BEYOND_USE;
				end else begin
					cmd.kind  = cmt_pkg::K_UPDATE;
					cmd.idx_a = source_cluster;
					cmd.idx_b = target_cluster;
					cmd.mode  = cmt_pkg::M_COPY;
				end
			end
			cmt_pkg::OP_REMOVE: begin
				if (tgt_w >= size_w) begin
					cmd.status = cmt_pkg::STAT_BEYOND_USE;
				end else begin
					cmd.kind   = cmt_pkg::K_REMOVE;
					cmd.idx_b  = target_cluster;
					size_after = size_q - cmt_pkg::SIZE_W'(1);
				end
			end
			cmt_pkg::OP_CLEAR: begin
				if (nsize_w > CAP) begin
					cmd.status = cmt_pkg::STAT_BEYOND_CAP;
				end else begin
					cmd.kind   = cmt_pkg::K_CLEAR;
					size_after = new_size;
				end
			end
		endcase
		cmd.size = size_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (accept) begin
			size_q <= size_after;
		end
	end

endmodule

`default_nettype wire

FILE: src/cmt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cmt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cmt_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output cmt_pkg::cmd_t      head
);

	cmt_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign full       = fill_q == 2'd2;
	assign head_valid = fill_q != 2'd0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/cmt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cmt_back #(
	parameter int MAX_CLUSTERS = 64,
	parameter int COUNT_BITS   = 17
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 head_valid,
	input  wire cmt_pkg::cmd_t                        head,
	output logic                                      pop,
	output logic                                      init_busy,
	output logic                                      done,
	output logic [cmt_pkg::STATUS_W-1:0]              status,
	output logic [cmt_pkg::SIZE_W-1:0]                clusters_in_use,
	output logic signed [cmt_pkg::OUT_CNT_W-1:0]      entry_count,
	output logic signed [cmt_pkg::SUM_W-1:0]          entry_sum,
	output logic signed [cmt_pkg::SQ_W-1:0]           entry_sum_squares
);

	localparam int AW = $clog2(MAX_CLUSTERS);
	localparam int PW = (AW > cmt_pkg::SIZE_W) ? AW : cmt_pkg::SIZE_W;
	localparam int XW = (COUNT_BITS > cmt_pkg::OUT_CNT_W) ? COUNT_BITS : cmt_pkg::OUT_CNT_W;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_A     = 3'd2;
	localparam logic [2:0] S_B     = 3'd3;
	localparam logic [2:0] S_RM    = 3'd4;
	localparam logic [2:0] S_RM_WR = 3'd5;

	typedef struct packed {
		logic [COUNT_BITS-1:0]     count;
		logic [cmt_pkg::SUM_W-1:0] sum;
		logic [cmt_pkg::SQ_W-1:0]  sq;
	} entry_t;

	entry_t     mem_q [MAX_CLUSTERS];
	entry_t     rd_q;
	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] ptr_d;
	logic       init_q;
	logic       init_d;

	logic          we;
	logic [AW-1:0] wa;
	entry_t        wd;
	logic [AW-1:0] ra;
	logic          res_fire;
	logic          res_has;

	logic signed [COUNT_BITS-1:0] cnt_s;
	logic signed [XW-1:0]         cnt_ext;

	function automatic entry_t apply(input entry_t e, input logic [1:0] mode,
			input logic [cmt_pkg::VAL_W-1:0] v, input logic [cmt_pkg::SQV_W-1:0] s);
		entry_t r;
		r = e;
		unique case (mode)
			cmt_pkg::M_ADD: begin
				r.count = e.count + COUNT_BITS'(1);
				r.sum   = e.sum + cmt_pkg::SUM_W'(v);
				r.sq    = e.sq + cmt_pkg::SQ_W'(s);
			end
			cmt_pkg::M_SUB: begin
				r.count = e.count - COUNT_BITS'(1);
				r.sum   = e.sum - cmt_pkg::SUM_W'(v);
				r.sq    = e.sq - cmt_pkg::SQ_W'(s);
			end
			default: r = e;
		endcase
		return r;
	endfunction

	assign init_busy = init_q;

	always_comb begin
		we       = 1'b0;
		wa       = AW'(head.idx_b);
		wd       = rd_q;
		ra       = AW'(head.idx_a);
		pop      = 1'b0;
		res_fire = 1'b0;
		res_has  = 1'b0;
		state_d  = state_q;
		ptr_d    = ptr_q;
		init_d   = init_q;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				wa = AW'(ptr_q);
				wd = '0;
				if (ptr_q == PW'(MAX_CLUSTERS - 1)) begin
					init_d  = 1'b0;
					state_d = S_IDLE;
					if (!init_q) begin
						res_fire = 1'b1;
						pop      = 1'b1;
					end
				end else begin
					ptr_d = ptr_q + PW'(1);
				end
			end
			S_IDLE: begin
				if (head_valid) begin
					unique case (head.kind)
						cmt_pkg::K_NONE: begin
							res_fire = 1'b1;
							pop      = 1'b1;
						end
						cmt_pkg::K_UPDATE: begin
							state_d = head.two_step ? S_A : S_B;
						end
						cmt_pkg::K_REMOVE: begin
							ptr_d   = PW'(head.idx_b);
							state_d = S_RM;
						end
						cmt_pkg::K_CLEAR: begin
							ptr_d   = '0;
							state_d = S_CLR;
						end
					endcase
				end
			end
			S_A: begin
				we      = 1'b1;
				wa      = AW'(head.idx_a);
				wd      = apply(rd_q, cmt_pkg::M_SUB, head.value, head.square);
				ra      = AW'(head.idx_b);
				state_d = S_B;
			end
			S_B: begin
				we       = 1'b1;
				wa       = AW'(head.idx_b);
				wd       = apply(rd_q, head.mode, head.value, head.square);
				res_fire = 1'b1;
				res_has  = 1'b1;
				pop      = 1'b1;
				state_d  = S_IDLE;
			end
			S_RM: begin
				if (ptr_q < PW'(head.size)) begin
					ra      = AW'(ptr_q + PW'(1));
					state_d = S_RM_WR;
				end else begin
					we       = 1'b1;
					wa       = AW'(ptr_q);
					wd       = '0;
					res_fire = 1'b1;
					pop      = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RM_WR: begin
				we      = 1'b1;
				wa      = AW'(ptr_q);
				wd      = rd_q;
				ptr_d   = ptr_q + PW'(1);
				state_d = S_RM;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cnt_s   = wd.count;
	assign cnt_ext = XW'(cnt_s);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ptr_q   <= '0;
			init_q  <= 1'b1;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			init_q  <= init_d;
			done    <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status          <= head.status;
			clusters_in_use <= head.size;
			if (res_has) begin
				entry_count       <= cnt_ext[cmt_pkg::OUT_CNT_W-1:0];
				entry_sum         <= wd.sum;
				entry_sum_squares <= wd.sq;
			end else begin
				entry_count       <= '0;
				entry_sum         <= '0;
				entry_sum_squares <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/cluster_moment_table_unit.sv
// Per-cluster moment table: count, sum and sum of squares of Q8.8 point values for up
// to MAX_CLUSTERS clusters, plus the number of clusters in use. A command is taken when
// start is high and busy is low; bounds are checked on entry and each command gives one
// result, shown for a single cycle with done high, which the receiver must take as it
// comes. All entries live in one table memory with a write port and a registered read
// port, so the memory sets the pace: an error or an assign with neither cluster gives
// its result from idle, an assign touching one cluster and a move do one read and one
// write, an assign between two different clusters updates the old entry and then the
// new one, a remove moves each entry above the target down by one and zeroes the last,
// and a clear zeroes every entry. Up to two commands wait in a queue ahead of the table,
// and busy rises when it is full. After reset the whole table is zeroed with busy high.
`timescale 1ns / 1ps
`default_nettype none

module cluster_moment_table_unit #(
	parameter int MAX_CLUSTERS = 64,
	parameter int VALUE_BITS   = 16,
	parameter int COUNT_BITS   = 17
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           opcode,
	input  wire logic                                 old_valid,
	input  wire logic [cmt_pkg::IDX_W-1:0]            prior_cluster,
	input  wire logic                                 new_valid,
	input  wire logic [cmt_pkg::IDX_W-1:0]            new_cluster,
	input  wire logic [cmt_pkg::VAL_W-1:0]            point_value,
	input  wire logic [cmt_pkg::IDX_W-1:0]            source_cluster,
	input  wire logic [cmt_pkg::IDX_W-1:0]            target_cluster,
	input  wire logic [cmt_pkg::SIZE_W-1:0]           new_size,
	output logic                                      done,
	output logic [cmt_pkg::STATUS_W-1:0]              status,
	output logic [cmt_pkg::SIZE_W-1:0]                clusters_in_use,
	output logic signed [cmt_pkg::OUT_CNT_W-1:0]      entry_count,
	output logic signed [cmt_pkg::SUM_W-1:0]          entry_sum,
	output logic signed [cmt_pkg::SQ_W-1:0]           entry_sum_squares
);

	logic          accept;
	logic          q_full;
	logic          head_valid;
	logic          pop;
	logic          init_busy;
	cmt_pkg::cmd_t front_cmd;
	cmt_pkg::cmd_t head;

	assign busy   = q_full | init_busy;
	assign accept = start & ~busy;

	cmt_front #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(opcode),
		.old_valid(old_valid),
		.prior_cluster(prior_cluster),
		.new_valid(new_valid),
		.new_cluster(new_cluster),
		.point_value(point_value),
		.source_cluster(source_cluster),
		.target_cluster(target_cluster),
		.new_size(new_size),
		.cmd(front_cmd)
	);

	cmt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_cmd(front_cmd),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head(head)
	);

	cmt_back #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.init_busy(init_busy),
		.done(done),
		.status(status),
		.clusters_in_use(clusters_in_use),
		.entry_count(entry_count),
		.entry_sum(entry_sum),
		.entry_sum_squares(entry_sum_squares)
	);

endmodule

`default_nettype wire

FILE: sim/tb_cluster_moment_table_unit.sv
`timescale 1ns / 1ps

module tb_cluster_moment_table_unit;

	localparam int TABLE_DEPTH    = 64;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 1125;

	typedef struct packed {
		logic [1:0]                 op;
		logic                       ov;
		logic [cmt_pkg::IDX_W-1:0]  oc;
		logic                       nv;
		logic [cmt_pkg::IDX_W-1:0]  nc;
		logic [cmt_pkg::VAL_W-1:0]  val;
		logic [cmt_pkg::IDX_W-1:0]  src;
		logic [cmt_pkg::IDX_W-1:0]  tgt;
		logic [cmt_pkg::SIZE_W-1:0] nsz;
	} table_cmd_t;

	typedef struct packed {
		logic [31:0]                   seq;
		logic [cmt_pkg::STATUS_W-1:0]  status;
		logic [cmt_pkg::SIZE_W-1:0]    size;
		logic [cmt_pkg::OUT_CNT_W-1:0] cnt;
		logic [cmt_pkg::SUM_W-1:0]     sum;
		logic [cmt_pkg::SQ_W-1:0]      sqsum;
	} moment_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = cmt_pkg::OP_ASSIGN;
	logic old_valid = 1'b0;
	logic [cmt_pkg::IDX_W-1:0] prior_cluster = '0;
	logic new_valid = 1'b0;
	logic [cmt_pkg::IDX_W-1:0] new_cluster = '0;
	logic [cmt_pkg::VAL_W-1:0] point_value = '0;
	logic [cmt_pkg::IDX_W-1:0] source_cluster = '0;
	logic [cmt_pkg::IDX_W-1:0] target_cluster = '0;
	logic [cmt_pkg::SIZE_W-1:0] new_size = '0;

	logic busy;
	logic done;
	logic [cmt_pkg::STATUS_W-1:0] status;
	logic [cmt_pkg::SIZE_W-1:0] clusters_in_use;
	logic signed [cmt_pkg::OUT_CNT_W-1:0] entry_count;
	logic signed [cmt_pkg::SUM_W-1:0] entry_sum;
	logic signed [cmt_pkg::SQ_W-1:0] entry_sum_squares;

	logic [cmt_pkg::OUT_CNT_W-1:0] cnt_tab [TABLE_DEPTH];
	logic [cmt_pkg::SUM_W-1:0] sum_tab [TABLE_DEPTH];
	logic [cmt_pkg::SQ_W-1:0] sqsum_tab [TABLE_DEPTH];
	logic [cmt_pkg::SIZE_W-1:0] tbl_size;

	moment_t pending_moments [$];

	int unsigned error_count = 0;
	int unsigned cmds_sent = 0;
	int unsigned results_seen = 0;
	int unsigned error_results = 0;
	int unsigned op_count [4] = '{0, 0, 0, 0};
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;

	cluster_moment_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.old_valid(old_valid),
		.prior_cluster(prior_cluster),
		.new_valid(new_valid),
		.new_cluster(new_cluster),
		.point_value(point_value),
		.source_cluster(source_cluster),
		.target_cluster(target_cluster),
		.new_size(new_size),
		.done(done),
		.status(status),
		.clusters_in_use(clusters_in_use),
		.entry_count(entry_count),
		.entry_sum(entry_sum),
		.entry_sum_squares(entry_sum_squares)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic moment_t apply_table_cmd(table_cmd_t c);
		moment_t r;
		logic hit;
		logic [cmt_pkg::IDX_W-1:0] idx;
		logic [cmt_pkg::SQ_W-1:0] sq;
		int i;
		r = '0;
		hit = 1'b0;
		idx = '0;
		sq = cmt_pkg::SQ_W'(c.val) * cmt_pkg::SQ_W'(c.val);
		case (c.op)
			cmt_pkg::OP_ASSIGN: begin
				if (c.ov && cmt_pkg::SIZE_W'(c.oc) >= tbl_size) begin
					r.status = cmt_pkg::STAT_BEYOND_USE;
				end else if (c.nv && int'(c.nc) >= TABLE_DEPTH) begin
					r.status = cmt_pkg::STAT_BEYOND_CAP;
				end else begin
					if (c.ov) begin
						cnt_tab[c.oc] = cnt_tab[c.oc] - cmt_pkg::OUT_CNT_W'(1);
						sum_tab[c.oc] = sum_tab[c.oc] - cmt_pkg::SUM_W'(c.val);
						sqsum_tab[c.oc] = sqsum_tab[c.oc] - sq;
						hit = 1'b1;
						idx = c.oc;
					end
					if (c.nv) begin
						if (cmt_pkg::SIZE_W'(c.nc) >= tbl_size)
							tbl_size = cmt_pkg::SIZE_W'(c.nc) + cmt_pkg::SIZE_W'(1);
						cnt_tab[c.nc] = cnt_tab[c.nc] + cmt_pkg::OUT_CNT_W'(1);
						sum_tab[c.nc] = sum_tab[c.nc] + cmt_pkg::SUM_W'(c.val);
						sqsum_tab[c.nc] = sqsum_tab[c.nc] + sq;
						hit = 1'b1;
						idx = c.nc;
					end
				end
			end
			cmt_pkg::OP_MOVE: begin
				if (cmt_pkg::SIZE_W'(c.src) >= tbl_size ||
						cmt_pkg::SIZE_W'(c.tgt) >= tbl_size) begin
					r.status = cmt_pkg::STAT_BEYOND_USE;
				end else begin
					cnt_tab[c.tgt] = cnt_tab[c.src];
					sum_tab[c.tgt] = sum_tab[c.src];
					sqsum_tab[c.tgt] = sqsum_tab[c.src];
					hit = 1'b1;
					idx = c.tgt;
				end
			end
			cmt_pkg::OP_REMOVE: begin
				if (cmt_pkg::SIZE_W'(c.tgt) >= tbl_size) begin
					r.status = cmt_pkg::STAT_BEYOND_USE;
				end else begin
					for (i = int'(c.tgt); i + 1 < int'(tbl_size); i++) begin
						cnt_tab[i] = cnt_tab[i + 1];
						sum_tab[i] = sum_tab[i + 1];
						sqsum_tab[i] = sqsum_tab[i + 1];
					end
					tbl_size = tbl_size - cmt_pkg::SIZE_W'(1);
					cnt_tab[tbl_size] = '0;
					sum_tab[tbl_size] = '0;
					sqsum_tab[tbl_size] = '0;
				end
			end
			default: begin
				if (int'(c.nsz) > TABLE_DEPTH) begin
					r.status = cmt_pkg::STAT_BEYOND_CAP;
				end else begin
					for (i = 0; i < TABLE_DEPTH; i++) begin
						cnt_tab[i] = '0;
						sum_tab[i] = '0;
						sqsum_tab[i] = '0;
					end
					tbl_size = c.nsz;
				end
			end
		endcase
		r.size = tbl_size;
		if (hit) begin
			r.cnt = cnt_tab[idx];
			r.sum = sum_tab[idx];
			r.sqsum = sqsum_tab[idx];
		end
		return r;
	endfunction

	function automatic table_cmd_t random_cmd();
		table_cmd_t c;
		c.op = 2'($urandom_range(0, 3));
		c.ov = 1'($urandom_range(0, 1));
		c.oc = cmt_pkg::IDX_W'($urandom_range(0, 63));
		c.nv = 1'($urandom_range(0, 1));
		c.nc = cmt_pkg::IDX_W'($urandom_range(0, 63));
		c.val = cmt_pkg::VAL_W'($urandom_range(0, 65535));
		c.src = cmt_pkg::IDX_W'($urandom_range(0, 63));
		c.tgt = cmt_pkg::IDX_W'($urandom_range(0, 63));
		c.nsz = cmt_pkg::SIZE_W'($urandom_range(0, 127));
		return c;
	endfunction

	function automatic logic [cmt_pkg::IDX_W-1:0] pick_index(int unsigned pct_in_use);
		if (tbl_size != '0 && $urandom_range(0, 99) < pct_in_use)
			return cmt_pkg::IDX_W'($urandom_range(0, int'(tbl_size) - 1));
		return cmt_pkg::IDX_W'($urandom_range(0, 63));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seq,
			input logic [63:0] expv, input logic [63:0] gotv);
		$display("%0t: transaction %0d %s: expected %0h got %0h",
			$time, seq, what, expv, gotv);
		error_count++;
	endtask

	task automatic send_cmd(input table_cmd_t c);
		moment_t r;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(0, 99) < 70 ? $urandom_range(1, 3) : $urandom_range(4, 15))
				@(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) :
				$urandom_range(1, 30);
		end
		start <= 1'b1;
		opcode <= c.op;
		old_valid <= c.ov;
		prior_cluster <= c.oc;
		new_valid <= c.nv;
		new_cluster <= c.nc;
		point_value <= c.val;
		source_cluster <= c.src;
		target_cluster <= c.tgt;
		new_size <= c.nsz;
		do
			@(posedge clk);
		while (busy);
		r = apply_table_cmd(c);
		r.seq = cmds_sent;
		pending_moments.push_back(r);
		cmds_sent++;
		op_count[c.op]++;
		burst_left--;
	endtask

	always @(posedge clk) begin
		moment_t e;
		if (arst_n && done) begin
			results_seen++;
			if (status != cmt_pkg::STAT_OK)
				error_results++;
			if (pending_moments.size() == 0) begin
				report_mismatch("result with no transaction pending", results_seen, '0,
					64'(status));
			end else begin
				e = pending_moments.pop_front();
				if (status !== e.status)
					report_mismatch("status", e.seq, 64'(e.status), 64'(status));
				if (clusters_in_use !== e.size)
					report_mismatch("clusters_in_use", e.seq, 64'(e.size),
						64'(clusters_in_use));
				if (entry_count !== e.cnt)
					report_mismatch("entry_count", e.seq, 64'(e.cnt),
						64'($unsigned(entry_count)));
				if (entry_sum !== e.sum)
					report_mismatch("entry_sum", e.seq, 64'(e.sum),
						64'($unsigned(entry_sum)));
				if (entry_sum_squares !== e.sqsum)
					report_mismatch("entry_sum_squares", e.seq, 64'(e.sqsum),
						64'($unsigned(entry_sum_squares)));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_cluster_moment_table_unit: errors");
			$finish;
		end
	end

	task automatic test_assign();
		table_cmd_t c;
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b1; c.oc = '0; c.nv = 1'b0;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b0; c.nv = 1'b0;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b0; c.nv = 1'b1; c.nc = 6'd63;
		c.val = 16'hFFFF;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b0; c.nv = 1'b1; c.nc = 6'd0;
		c.val = 16'h0000;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b1; c.oc = 6'd5; c.nv = 1'b0;
		c.val = 16'h1234;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b1; c.oc = 6'd63; c.nv = 1'b1; c.nc = 6'd63;
		c.val = 16'hABCD;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b1; c.oc = 6'd63; c.nv = 1'b1; c.nc = 6'd2;
		c.val = 16'hFFFF;
		send_cmd(c);
	endtask

	task automatic test_move();
		table_cmd_t c;
		c = random_cmd();
		c.op = cmt_pkg::OP_CLEAR; c.nsz = 7'd4;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b0; c.nv = 1'b1; c.nc = 6'd1;
		c.val = 16'h8001;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_MOVE; c.src = 6'd1; c.tgt = 6'd3;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_MOVE; c.src = 6'd4; c.tgt = 6'd0;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_MOVE; c.src = 6'd0; c.tgt = 6'd4;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_MOVE; c.src = 6'd3; c.tgt = 6'd3;
		send_cmd(c);
	endtask

	task automatic test_remove();
		table_cmd_t c;
		c = random_cmd();
		c.op = cmt_pkg::OP_ASSIGN; c.ov = 1'b0; c.nv = 1'b1; c.nc = 6'd2;
		c.val = 16'h00FF;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd1;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd2;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd2;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd0;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd0;
		send_cmd(c);
	endtask

	task automatic test_clear();
		table_cmd_t c;
		c = random_cmd();
		c.op = cmt_pkg::OP_CLEAR; c.nsz = 7'd65;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_CLEAR; c.nsz = 7'd127;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_CLEAR; c.nsz = 7'd64;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_REMOVE; c.tgt = 6'd0;
		send_cmd(c);
		c = random_cmd();
		c.op = cmt_pkg::OP_CLEAR; c.nsz = 7'd0;
		send_cmd(c);
	endtask

	task automatic test_random_mix(input int unsigned n_items);
		table_cmd_t c;
		int unsigned sent;
		int unsigned r;
		int unsigned g;
		sent = 0;
		while (sent < n_items) begin
			c = random_cmd();
			c.op = cmt_pkg::OP_CLEAR;
			r = $urandom_range(0, 99);
			if (r < 15)
				c.nsz = '0;
			else if (r < 70)
				c.nsz = cmt_pkg::SIZE_W'($urandom_range(1, 16));
			else if (r < 92)
				c.nsz = cmt_pkg::SIZE_W'($urandom_range(17, 64));
			else
				c.nsz = cmt_pkg::SIZE_W'($urandom_range(65, 127));
			send_cmd(c);
			sent++;
			repeat ($urandom_range(10, 60)) begin
				c = random_cmd();
				r = $urandom_range(0, 99);
				if (r < 68) begin
					c.op = cmt_pkg::OP_ASSIGN;
					c.ov = (tbl_size != '0) ? ($urandom_range(0, 99) < 75) :
						($urandom_range(0, 99) < 5);
					c.oc = pick_index(90);
					c.nv = $urandom_range(0, 99) < 85;
					g = $urandom_range(0, 99);
					if (g < 65) begin
						c.nc = pick_index(100);
					end else if (g < 85) begin
						g = 32'(tbl_size) + $urandom_range(0, 3);
						c.nc = cmt_pkg::IDX_W'((g > 63) ? $urandom_range(0, 63) : g);
					end
				end else if (r < 80) begin
					c.op = cmt_pkg::OP_MOVE;
					c.src = pick_index(85);
					c.tgt = pick_index(85);
				end else if (r < 88) begin
					c.op = cmt_pkg::OP_REMOVE;
					c.tgt = pick_index(85);
				end
				send_cmd(c);
				sent++;
			end
		end
	endtask

	initial begin
		tbl_size = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cnt_tab[i] = '0;
			sum_tab[i] = '0;
			sqsum_tab[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_assign();
		test_move();
		test_remove();
		test_clear();
		test_random_mix(RANDOM_ITEMS);
		start <= 1'b0;
		while (pending_moments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_moments.size() != 0)
			report_mismatch("results still outstanding", cmds_sent,
				64'(pending_moments.size()), '0);
		$display("run covered %0d transactions: %0d assign, %0d move, %0d remove, %0d clear",
			cmds_sent, op_count[cmt_pkg::OP_ASSIGN], op_count[cmt_pkg::OP_MOVE],
			op_count[cmt_pkg::OP_REMOVE], op_count[cmt_pkg::OP_CLEAR]);
		$display("%0d results checked, %0d with an error status, %0d mismatches",
			results_seen, error_results, error_count);
		if (error_count == 0)
			$display("tb_cluster_moment_table_unit: clean");
		else
			$display("tb_cluster_moment_table_unit: errors");
		$finish;
	end

endmodule

FILE: sim.f
src/cmt_pkg.sv
src/cmt_front.sv
src/cmt_queue.sv
src/cmt_back.sv
src/cluster_moment_table_unit.sv
sim/tb_cluster_moment_table_unit.sv
